// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the arc fan tessellator checkers.
// Expects aclk and aresetn in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every clock edge outside reset.
`define EAFT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Check that a condition is followed by another in the next cycle.
`define EAFT_ASSERT_NEXT(label, ante, cons, msg) \
    `EAFT_ASSERT(label, (ante) |=> (cons), msg)

`endif

// ===== rtl/core/eaft_pkg.sv =====
// Shared types, constants and the arctangent table of the arc fan tessellator.
// No dependencies; used by every module of the block but the checker.
`default_nettype none

package eaft_pkg;

    localparam int unsigned MAX_SEGMENTS_DEF      = 63;
    localparam int unsigned MIN_AUTO_SEGMENTS_DEF = 8;

    localparam int unsigned IN_DATA_W  = 104;
    localparam int unsigned OUT_DATA_W = 88;

    localparam int unsigned CORDIC_STEPS = 18;
    localparam int unsigned XY_W         = 33;
    localparam int unsigned Z_W          = 25;
    localparam int unsigned OFF_W        = 28;
    localparam int unsigned ACC_W        = 27;
    localparam int unsigned DIVIDEND_W   = 28;
    localparam int unsigned DIVISOR_W    = 16;

    localparam int FULL_TURN_FINE    = 23592960;
    localparam int HALF_TURN_FINE    = 11796480;
    localparam int QUARTER_TURN_FINE = 5898240;
    localparam logic signed [16:0] FULL_TURN_IN = 17'sd23040;

    localparam logic signed [XY_W-1:0] X_INIT = 33'sh026DD3B6A;

    typedef struct packed {
        logic [31:0]        fill_colour;
        logic [5:0]         segment_request;
        logic signed [15:0] arc_end;
        logic signed [15:0] arc_start;
        logic [15:0]        rad_y;
        logic [15:0]        rad_x;
    } req_t;

    typedef struct packed {
        logic [5:0]  vn;
        logic        centre;
        logic        last;
        logic [15:0] rx;
        logic [15:0] ry;
        logic [31:0] colour;
    } vtx_meta_t;

    typedef struct packed {
        logic               tri_third;
        logic [5:0]         tri_second;
        logic [5:0]         tri_first;
        logic               tri_valid;
        logic [31:0]        vertex_colour;
        logic signed [16:0] pos_y;
        logic signed [16:0] pos_x;
        logic [5:0]         vertex_number;
    } vtx_out_t;

    function automatic logic signed [Z_W-1:0] arc_angle(input int unsigned i);
        logic signed [Z_W-1:0] r;
        case (i)
            0:       r = 25'sd2949120;
            1:       r = 25'sd1740967;
            2:       r = 25'sd919879;
            3:       r = 25'sd466945;
            4:       r = 25'sd234379;
            5:       r = 25'sd117302;
            6:       r = 25'sd58665;
            7:       r = 25'sd29335;
            8:       r = 25'sd14668;
            9:       r = 25'sd7334;
            10:      r = 25'sd3667;
            11:      r = 25'sd1833;
            12:      r = 25'sd917;
            13:      r = 25'sd458;
            14:      r = 25'sd229;
            15:      r = 25'sd115;
            16:      r = 25'sd57;
            17:      r = 25'sd29;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ellipse_arc_fan_tessellator.sv =====
// Sequence: after the request beat, setup (and a count-scaling state when the automatic
// count is scaled by the sweep), the 28-step serial divider for the angle step, then
// the issue register and the vertex pipeline through the CORDIC and the output end.
// Throughput: one vertex beat per cycle unless stalled; a new request is taken only once
// the previous one has issued its last vertex; a stalled output freezes the pipeline.
// Reset: synchronous on aresetn low; clears sequencer state and all valid bits.
`default_nettype none

module ellipse_arc_fan_tessellator #(
    parameter int unsigned MAX_SEGMENTS      = eaft_pkg::MAX_SEGMENTS_DEF,
    parameter int unsigned MIN_AUTO_SEGMENTS = eaft_pkg::MIN_AUTO_SEGMENTS_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // rad_x, rad_y, arc_start, arc_end, segment_request, fill_colour
    input  wire logic [eaft_pkg::IN_DATA_W-1:0]   s_tdata,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // vertex_number, pos_x, pos_y, vertex_colour, tri_valid, tri_first,
    // tri_second, tri_third
    output logic [eaft_pkg::OUT_DATA_W-1:0]       m_tdata,
    output logic                                  m_tlast
);
    import eaft_pkg::*;

    req_t                    req;
    logic                    pipe_en;
    logic                    issue_valid;
    vtx_meta_t               issue_meta;
    logic signed [15:0]      issue_start;
    logic signed [OFF_W-1:0] issue_offset;
    logic                    rot_valid;
    vtx_meta_t               rot_meta;
    logic signed [XY_W-1:0]  rot_x;
    logic signed [XY_W-1:0]  rot_y;
    logic                    rot_neg;
    vtx_out_t                out_data;

    assign req = s_tdata[$bits(req_t)-1:0];

    eaft_seq #(
        .MAX_SEGMENTS      (MAX_SEGMENTS),
        .MIN_AUTO_SEGMENTS (MIN_AUTO_SEGMENTS)
    ) u_seq (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .req          (req),
        .pipe_en      (pipe_en),
        .issue_valid  (issue_valid),
        .issue_meta   (issue_meta),
        .issue_start  (issue_start),
        .issue_offset (issue_offset)
    );

    eaft_cordic u_cordic (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pipe_en   (pipe_en),
        .in_valid  (issue_valid),
        .in_meta   (issue_meta),
        .in_start  (issue_start),
        .in_offset (issue_offset),
        .out_valid (rot_valid),
        .out_meta  (rot_meta),
        .out_x     (rot_x),
        .out_y     (rot_y),
        .out_neg   (rot_neg)
    );

    eaft_scale u_scale (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .pipe_en  (pipe_en),
        .in_valid (rot_valid),
        .in_meta  (rot_meta),
        .in_x     (rot_x),
        .in_y     (rot_y),
        .in_neg   (rot_neg),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_data   (out_data),
        .m_last   (m_tlast)
    );

    assign m_tdata = {(OUT_DATA_W - $bits(vtx_out_t))'(0), out_data};

endmodule

`default_nettype wire

// ===== rtl/core/eaft_div.sv =====
// Restoring serial divider, one quotient bit per cycle.
// Depends on eaft_pkg for default widths.
`default_nettype none

module eaft_div #(
    parameter int unsigned DW  = eaft_pkg::DIVIDEND_W,
    parameter int unsigned DSW = eaft_pkg::DIVISOR_W
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           start,
    input  wire logic [DW-1:0]  dividend,
    input  wire logic [DSW-1:0] divisor,
    output logic                done,
    output logic [DW-1:0]       quotient,
    output logic [DSW-1:0]      remainder
);
    localparam int unsigned IT_W = (DW > 1) ? $clog2(DW) : 1;

    logic            busy_reg;
    logic            done_reg;
    logic [IT_W-1:0] it_reg;
    logic [DW-1:0]   dvd_reg;
    logic [DSW-1:0]  div_reg;
    logic [DSW-1:0]  rem_reg;
    logic [DSW:0]    trial;
    logic            ge;
    logic [DSW:0]    rem_next;

    assign trial    = {rem_reg, dvd_reg[DW-1]};
    assign ge       = trial >= {1'b0, div_reg};
    assign rem_next = ge ? (trial - {1'b0, div_reg}) : trial;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            it_reg   <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                it_reg   <= '0;
                dvd_reg  <= dividend;
                div_reg  <= divisor;
                rem_reg  <= '0;
            end else if (busy_reg) begin
                rem_reg <= rem_next[DSW-1:0];
                dvd_reg <= {dvd_reg[DW-2:0], ge};
                it_reg  <= it_reg + 1'b1;
                if (it_reg == IT_W'(DW - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done      = done_reg;
    assign quotient  = dvd_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

// ===== rtl/core/eaft_seq.sv =====
// Request sequencer: point count, angle step and vertex issue.
// Depends on eaft_pkg and eaft_div.
`default_nettype none

module eaft_seq #(
    parameter int unsigned MAX_SEGMENTS      = eaft_pkg::MAX_SEGMENTS_DEF,
    parameter int unsigned MIN_AUTO_SEGMENTS = eaft_pkg::MIN_AUTO_SEGMENTS_DEF
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    input  wire eaft_pkg::req_t            req,
    input  wire logic                      pipe_en,
    output logic                           issue_valid,
    output eaft_pkg::vtx_meta_t            issue_meta,
    output logic signed [15:0]             issue_start,
    output logic signed [eaft_pkg::OFF_W-1:0] issue_offset
);
    import eaft_pkg::*;

    // count scaling: prod / 23040 = (prod >> 9) / 45, via reciprocal 2913 / 2^17
    localparam int unsigned CNT_SAT_PROD = 64 * 23040;
    localparam int unsigned RECIP_45     = 2913;

    typedef enum logic [2:0] {
        ST_IDLE, ST_SETUP, ST_CNT_DIV, ST_STEP_START, ST_STEP_DIV, ST_CENTRE, ST_EMIT
    } state_t;

    state_t                   state_reg;
    req_t                     req_reg;
    logic signed [16:0]       sweep_reg;
    logic [5:0]               cnt_reg;
    logic [ACC_W-1:0]         qm_reg;
    logic [5:0]               rm_reg;
    logic [ACC_W-1:0]         q_acc_reg;
    logic [5:0]               r_acc_reg;
    logic [5:0]               idx_reg;
    logic                     div_start_reg;
    logic [DIVIDEND_W-1:0]    dividend_reg;
    logic [DIVISOR_W-1:0]     divisor_reg;
    logic                     issue_valid_reg;
    vtx_meta_t                issue_meta_reg;
    logic signed [15:0]       issue_start_reg;
    logic signed [OFF_W-1:0]  issue_offset_reg;

    logic                     div_done;
    logic [DIVIDEND_W-1:0]    div_quot;
    logic [DIVISOR_W-1:0]     div_rem;

    logic [11:0]              rmax;
    logic [DIVIDEND_W-1:0]    cnt_prod;
    logic [22:0]              recip_prod;
    logic [6:0]               cnt_quot;
    logic [15:0]              sweep_abs;
    logic [5:0]               den;
    logic [6:0]               r_sum;
    logic [5:0]               explicit_cnt;

    function automatic logic [5:0] clamp_auto(input logic [DIVIDEND_W-1:0] v);
        logic [5:0] r;
        if (v > DIVIDEND_W'(MAX_SEGMENTS))
            r = 6'(MAX_SEGMENTS);
        else
            r = v[5:0];
        if (v < DIVIDEND_W'(MIN_AUTO_SEGMENTS))
            r = (MIN_AUTO_SEGMENTS > MAX_SEGMENTS) ? 6'(MAX_SEGMENTS)
                                                    : 6'(MIN_AUTO_SEGMENTS);
        return r;
    endfunction

    eaft_div #(.DW(DIVIDEND_W), .DSW(DIVISOR_W)) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start_reg),
        .dividend  (dividend_reg),
        .divisor   (divisor_reg),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    assign rmax      = (req_reg.rad_x > req_reg.rad_y) ? req_reg.rad_x[15:4]
                                                       : req_reg.rad_y[15:4];
    assign cnt_prod  = DIVIDEND_W'(rmax) * DIVIDEND_W'(sweep_reg[15:0]);
    assign recip_prod = 23'(dividend_reg[20:9]) * 23'(RECIP_45);
    assign cnt_quot  = (dividend_reg >= DIVIDEND_W'(CNT_SAT_PROD)) ? 7'd64
                                                                   : {1'b0, recip_prod[22:17]};
    assign sweep_abs = sweep_reg[16] ? 16'(-sweep_reg) : sweep_reg[15:0];
    assign den       = cnt_reg - 6'd1;
    assign r_sum     = {1'b0, r_acc_reg} + {1'b0, rm_reg};
    assign explicit_cnt = (req_reg.segment_request < 6'd2) ? 6'd2 :
                          (req_reg.segment_request > 6'(MAX_SEGMENTS)) ? 6'(MAX_SEGMENTS) :
                          req_reg.segment_request;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            div_start_reg   <= 1'b0;
            issue_valid_reg <= 1'b0;
        end else begin
            div_start_reg <= 1'b0;
            if (pipe_en)
                issue_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        req_reg   <= req;
                        sweep_reg <= 17'(req.arc_end) - 17'(req.arc_start);
                        state_reg <= ST_SETUP;
                    end
                end
                ST_SETUP: begin
                    if (req_reg.segment_request != 6'd0) begin
                        cnt_reg   <= explicit_cnt;
                        state_reg <= ST_STEP_START;
                    end else if (sweep_reg == FULL_TURN_IN) begin
                        cnt_reg   <= clamp_auto(DIVIDEND_W'(rmax));
                        state_reg <= ST_STEP_START;
                    end else if (sweep_reg <= 17'sd0) begin
                        cnt_reg   <= clamp_auto('0);
                        state_reg <= ST_STEP_START;
                    end else begin
                        dividend_reg  <= cnt_prod;
                        state_reg     <= ST_CNT_DIV;
                    end
                end
                ST_CNT_DIV: begin
                    cnt_reg   <= clamp_auto(DIVIDEND_W'(cnt_quot));
                    state_reg <= ST_STEP_START;
                end
                ST_STEP_START: begin
                    div_start_reg <= 1'b1;
                    dividend_reg  <= {2'b00, sweep_abs, 10'd0};
                    divisor_reg   <= DIVISOR_W'(den);
                    state_reg     <= ST_STEP_DIV;
                end
                ST_STEP_DIV: begin
                    if (div_done) begin
                        qm_reg    <= div_quot[ACC_W-1:0];
                        rm_reg    <= div_rem[5:0];
                        q_acc_reg <= '0;
                        r_acc_reg <= den >> 1;
                        idx_reg   <= '0;
                        state_reg <= ST_CENTRE;
                    end
                end
                ST_CENTRE: begin
                    if (pipe_en) begin
                        issue_valid_reg         <= 1'b1;
                        issue_meta_reg.vn       <= '0;
                        issue_meta_reg.centre   <= 1'b1;
                        issue_meta_reg.last     <= 1'b0;
                        issue_meta_reg.rx       <= req_reg.rad_x;
                        issue_meta_reg.ry       <= req_reg.rad_y;
                        issue_meta_reg.colour   <= req_reg.fill_colour;
                        issue_start_reg         <= req_reg.arc_start;
                        issue_offset_reg        <= '0;
                        state_reg               <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (pipe_en) begin
                        issue_valid_reg       <= 1'b1;
                        issue_meta_reg.vn     <= idx_reg + 6'd1;
                        issue_meta_reg.centre <= 1'b0;
                        issue_meta_reg.last   <= (idx_reg == den);
                        issue_offset_reg      <= sweep_reg[16] ? -OFF_W'(q_acc_reg)
                                                               : OFF_W'(q_acc_reg);
                        if (r_sum >= {1'b0, den}) begin
                            r_acc_reg <= 6'(r_sum - {1'b0, den});
                            q_acc_reg <= q_acc_reg + qm_reg + 1'b1;
                        end else begin
                            r_acc_reg <= r_sum[5:0];
                            q_acc_reg <= q_acc_reg + qm_reg;
                        end
                        idx_reg <= idx_reg + 6'd1;
                        if (idx_reg == den)
                            state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_tready     = (state_reg == ST_IDLE);
    assign issue_valid  = issue_valid_reg;
    assign issue_meta   = issue_meta_reg;
    assign issue_start  = issue_start_reg;
    assign issue_offset = issue_offset_reg;

endmodule

`default_nettype wire

// ===== rtl/core/eaft_cordic.sv =====
// Angle pipeline: absolute angle, wrap, fold and an 18-stage rotation CORDIC.
// Depends on eaft_pkg.
`default_nettype none

module eaft_cordic (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          pipe_en,
    input  wire logic                          in_valid,
    input  wire eaft_pkg::vtx_meta_t           in_meta,
    input  wire logic signed [15:0]            in_start,
    input  wire logic signed [eaft_pkg::OFF_W-1:0] in_offset,
    output logic                               out_valid,
    output eaft_pkg::vtx_meta_t                out_meta,
    output logic signed [eaft_pkg::XY_W-1:0]   out_x,
    output logic signed [eaft_pkg::XY_W-1:0]   out_y,
    output logic                               out_neg
);
    import eaft_pkg::*;

    localparam int unsigned N = CORDIC_STEPS;

    logic                    a_valid_reg;
    vtx_meta_t               a_meta_reg;
    logic signed [28:0]      a_angle_reg;
    logic                    w_valid_reg;
    vtx_meta_t               w_meta_reg;
    logic signed [Z_W-1:0]   w_angle_reg;

    logic                    v_reg    [0:N];
    vtx_meta_t               meta_reg [0:N];
    logic                    neg_reg  [0:N];
    logic signed [XY_W-1:0]  x_reg    [0:N];
    logic signed [XY_W-1:0]  y_reg    [0:N];
    logic signed [Z_W-1:0]   z_reg    [0:N];

    logic signed [28:0]      a_sum;
    logic signed [Z_W-1:0]   w_angle;
    logic signed [Z_W-1:0]   f_angle;
    logic                    f_neg;

    function automatic logic signed [Z_W-1:0] wrap_turn(input logic signed [28:0] a);
        logic signed [31:0]    t;
        logic signed [Z_W-1:0] r;
        r = '0;
        for (int k = -5; k <= 5; k++) begin
            t = 32'(a) - 32'(k * FULL_TURN_FINE);
            if (t >= -HALF_TURN_FINE && t < HALF_TURN_FINE)
                r = t[Z_W-1:0];
        end
        return r;
    endfunction

    assign a_sum   = $signed({{3{in_start[15]}}, in_start, 10'd0}) + 29'(in_offset);
    assign w_angle = wrap_turn(a_angle_reg);

    always_comb begin
        f_angle = w_angle_reg;
        f_neg   = 1'b0;
        if (w_angle_reg > Z_W'(QUARTER_TURN_FINE)) begin
            f_angle = w_angle_reg - Z_W'(HALF_TURN_FINE);
            f_neg   = 1'b1;
        end else if (w_angle_reg < -Z_W'(QUARTER_TURN_FINE)) begin
            f_angle = w_angle_reg + Z_W'(HALF_TURN_FINE);
            f_neg   = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            w_valid_reg <= 1'b0;
            v_reg[0]    <= 1'b0;
        end else if (pipe_en) begin
            a_valid_reg <= in_valid;
            a_meta_reg  <= in_meta;
            a_angle_reg <= a_sum;
            w_valid_reg <= a_valid_reg;
            w_meta_reg  <= a_meta_reg;
            w_angle_reg <= w_angle;
            v_reg[0]    <= w_valid_reg;
            meta_reg[0] <= w_meta_reg;
            neg_reg[0]  <= f_neg;
            x_reg[0]    <= X_INIT;
            y_reg[0]    <= '0;
            z_reg[0]    <= f_angle;
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_step
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[i+1] <= 1'b0;
            end else if (pipe_en) begin
                v_reg[i+1]    <= v_reg[i];
                meta_reg[i+1] <= meta_reg[i];
                neg_reg[i+1]  <= neg_reg[i];
                if (z_reg[i] >= 0) begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - arc_angle(i);
                end else begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + arc_angle(i);
                end
            end
        end
    end

    assign out_valid = v_reg[N];
    assign out_meta  = meta_reg[N];
    assign out_x     = x_reg[N];
    assign out_y     = y_reg[N];
    assign out_neg   = neg_reg[N];

endmodule

`default_nettype wire

// ===== rtl/core/eaft_scale.sv =====
// Output end: round and clamp sine and cosine, scale by the radii, register the beat.
// Depends on eaft_pkg.
`default_nettype none

module eaft_scale (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    output logic                             pipe_en,
    input  wire logic                        in_valid,
    input  wire eaft_pkg::vtx_meta_t         in_meta,
    input  wire logic signed [eaft_pkg::XY_W-1:0] in_x,
    input  wire logic signed [eaft_pkg::XY_W-1:0] in_y,
    input  wire logic                        in_neg,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output eaft_pkg::vtx_out_t               m_data,
    output logic                             m_last
);
    import eaft_pkg::*;

    logic               r_valid_reg;
    vtx_meta_t          r_meta_reg;
    logic signed [17:0] r_c_reg;
    logic signed [17:0] r_s_reg;
    logic               p_valid_reg;
    vtx_meta_t          p_meta_reg;
    logic signed [34:0] p_x_reg;
    logic signed [34:0] p_y_reg;
    logic               o_valid_reg;
    vtx_out_t           o_data_reg;
    logic               o_last_reg;

    logic signed [17:0] c_q16;
    logic signed [17:0] s_q16;
    logic [16:0]        mx;
    logic [16:0]        my;
    logic signed [16:0] px;
    logic signed [16:0] py;
    vtx_out_t           o_data_next;

    function automatic logic signed [17:0] round_q16(input logic signed [XY_W-1:0] v);
        logic signed [XY_W-1:0] t;
        logic signed [17:0]     r;
        t = (v + XY_W'(8192)) >>> 14;
        if (t > XY_W'(65536))
            r = 18'sd65536;
        else if (t < -XY_W'(65536))
            r = -18'sd65536;
        else
            r = t[17:0];
        return r;
    endfunction

    function automatic logic [16:0] round_mag(input logic signed [34:0] p);
        logic [34:0] m;
        m = p[34] ? 35'(-p) : 35'(p);
        m = m + 35'd32768;
        return m[32:16];
    endfunction

    assign pipe_en = !o_valid_reg || m_ready;

    assign c_q16 = in_neg ? -round_q16(in_x) : round_q16(in_x);
    assign s_q16 = in_neg ? -round_q16(in_y) : round_q16(in_y);

    assign mx = round_mag(p_x_reg);
    assign my = round_mag(p_y_reg);
    assign px = p_x_reg[34] ? -$signed(mx) : $signed(mx);
    assign py = p_y_reg[34] ? $signed(my) : -$signed(my);

    always_comb begin
        o_data_next.vertex_number = p_meta_reg.vn;
        o_data_next.vertex_colour = p_meta_reg.colour;
        o_data_next.pos_x         = p_meta_reg.centre ? '0 : px;
        o_data_next.pos_y         = p_meta_reg.centre ? '0 : py;
        o_data_next.tri_valid     = (p_meta_reg.vn >= 6'd2);
        o_data_next.tri_first     = (p_meta_reg.vn >= 6'd2) ? p_meta_reg.vn : '0;
        o_data_next.tri_second    = (p_meta_reg.vn >= 6'd2) ? (p_meta_reg.vn - 6'd1) : '0;
        o_data_next.tri_third     = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r_valid_reg <= 1'b0;
            p_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            r_valid_reg <= in_valid;
            r_meta_reg  <= in_meta;
            r_c_reg     <= c_q16;
            r_s_reg     <= s_q16;
            p_valid_reg <= r_valid_reg;
            p_meta_reg  <= r_meta_reg;
            p_x_reg     <= $signed({1'b0, r_meta_reg.rx}) * r_c_reg;
            p_y_reg     <= $signed({1'b0, r_meta_reg.ry}) * r_s_reg;
            o_valid_reg <= p_valid_reg;
            o_data_reg  <= o_data_next;
            o_last_reg  <= p_meta_reg.last;
        end
    end

    assign m_valid = o_valid_reg;
    assign m_data  = o_data_reg;
    assign m_last  = o_last_reg;

endmodule

`default_nettype wire

// ===== rtl/core/eaft_checker.sv =====
// Port-level checks on the vertex stream of the arc fan tessellator.
// Depends on assert_macros.svh; bound to ellipse_arc_fan_tessellator.
`default_nettype none

`include "assert_macros.svh"

module eaft_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [103:0] s_tdata,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [87:0] m_tdata,
    input wire logic        m_tlast
);
    logic       expect_start_reg;
    logic [5:0] prev_vn_reg;
    logic [5:0] vn;
    logic       tv;
    logic [5:0] t1;
    logic [5:0] t2;
    logic       t3;

    assign vn = m_tdata[5:0];
    assign tv = m_tdata[72];
    assign t1 = m_tdata[78:73];
    assign t2 = m_tdata[84:79];
    assign t3 = m_tdata[85];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expect_start_reg <= 1'b1;
            prev_vn_reg      <= '0;
        end else if (m_tvalid && m_tready) begin
            expect_start_reg <= m_tlast;
            prev_vn_reg      <= vn;
        end
    end

    `EAFT_ASSERT_NEXT(a_stall_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "beat changed while stalled")
    `EAFT_ASSERT(a_run_start, (m_tvalid && expect_start_reg) |-> (vn == 6'd0 && !m_tlast), "run does not open with the centre")
    `EAFT_ASSERT(a_run_order, (m_tvalid && !expect_start_reg) |-> (vn == prev_vn_reg + 6'd1), "vertex number out of order")
    `EAFT_ASSERT(a_fan_tri, m_tvalid |-> (!t3 && (tv == (vn >= 6'd2)) && (!tv || (t1 == vn && t2 == vn - 6'd1))), "fan triangle indices wrong")

endmodule

bind ellipse_arc_fan_tessellator eaft_checker u_eaft_checker (.*);

`default_nettype wire
